// File: hw/rtl/btcr_pkg.sv
// Package: shared types and constants for the box table collision resolver.
`timescale 1ns / 1ps
package btcr_pkg;

  localparam int BOX_COUNT  = 64;
  localparam int IDX_BITS   = 6;
  localparam int COORD_BITS = 24;
  localparam int HALF_BITS  = 23;
  localparam logic signed [COORD_BITS-1:0] NUDGE = 24'sd26;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    CONTACT_NONE  = 2'd0,
    CONTACT_TOP   = 2'd1,
    CONTACT_UNDER = 2'd2,
    CONTACT_SIDE  = 2'd3
  } contact_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  kind;
    logic [IDX_BITS-1:0]   entry_index;
    logic                  entry_active;
    coord_t                a_x;
    coord_t                a_y;
    coord_t                a_z;
    coord_t                b_x;
    coord_t                b_y;
    coord_t                b_z;
    logic [HALF_BITS-1:0]  half_x;
    logic [HALF_BITS-1:0]  half_y;
    logic [HALF_BITS-1:0]  half_z;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]            contact;
    logic                  hit_found;
    logic [IDX_BITS-1:0]   hit_entry;
    coord_t                out_x;
    coord_t                out_y;
    coord_t                out_z;
    logic                  stop_x;
    logic                  stop_y;
    logic                  stop_z;
  } out_beat_t;

  typedef struct packed {
    coord_t lx;
    coord_t ly;
    coord_t lz;
    coord_t ux;
    coord_t uy;
    coord_t uz;
  } box_t;

endpackage

// File: hw/rtl/box_table_collision_resolve.sv
// Top level: box table with a sequential collision walk per query.
`timescale 1ns / 1ps
// Write beats load one table entry; out_valid is registered from the ST_DONE
// state that follows the accepting edge. Query beats walk all 64 entries through
// the box memory, one entry read per cycle, then pass ST_DONE before out_valid
// rises; the single read port of the box memory and the chained correction per
// entry make the walk sequential. busy is high while an item is in work and drops
// in the out_valid cycle, so the next item can be accepted there. out_valid pulses for
// one cycle with the result and the receiver cannot stall it. Entry live bits
// reset to zero; box bounds are undefined until written.
module box_table_collision_resolve
  import btcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  output out_beat_t out_beat
);

  box_t                box_mem [BOX_COUNT];
  logic [BOX_COUNT-1:0] live_r;
  box_t                rd_box_r;
  logic                rd_live_r;
  logic                rd_vld_r;
  logic [IDX_BITS-1:0] rd_idx_r;

  state_t state_r, state_nxt;
  logic [IDX_BITS:0] addr_r, addr_nxt;
  coord_t px_r, py_r, pz_r, ox_r, oy_r, oz_r;
  coord_t hx_r, hy_r, hz_r;
  logic [1:0] contact_r;
  logic found_r, sx_r, sy_r, sz_r;
  logic [IDX_BITS-1:0] last_r;
  out_beat_t out_r;
  logic out_vld_r;
  logic kind_q_r;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Memory write port and registered read port.
  always_ff @(posedge clk) begin
    if (accept && in_beat.kind == KIND_WRITE) begin
      box_mem[in_beat.entry_index] <= '{in_beat.a_x, in_beat.a_y, in_beat.a_z,
                                        in_beat.b_x, in_beat.b_y, in_beat.b_z};
    end
    rd_box_r <= box_mem[addr_r[IDX_BITS-1:0]];
    rd_idx_r <= addr_r[IDX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r    <= '0;
      rd_live_r <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (accept && in_beat.kind == KIND_WRITE) begin
        live_r[in_beat.entry_index] <= in_beat.entry_active;
      end
      rd_live_r <= live_r[addr_r[IDX_BITS-1:0]];
      rd_vld_r  <= (state_r == ST_WALK) && !addr_r[IDX_BITS];
    end
  end

  // Collision step for the entry read last cycle.
  coord_t nx, ny, nz;
  logic [1:0] ncontact;
  logic nsx, nsy, nsz, hit;
  always_comb begin
    box_t b;
    b = rd_box_r;
    nx = px_r; ny = py_r; nz = pz_r;
    ncontact = contact_r; nsx = sx_r; nsy = sy_r; nsz = sz_r; hit = 1'b0;
    if (rd_vld_r && rd_live_r) begin
      if ((ny + hy_r) > b.ly && (ny - hy_r) < b.uy) begin
        if ((nz + hz_r) > b.lz && (nz - hz_r) < b.uz) begin
          if ((nx + hz_r) > b.lx && (ox_r + hz_r) <= b.lx) begin
            nx = b.lx - hz_r; nsx = 1'b1; ncontact = CONTACT_SIDE; hit = 1'b1;
          end else if ((nx - hz_r) < b.ux && (ox_r - hz_r) >= b.ux) begin
            nx = b.ux + hz_r; nsx = 1'b1; ncontact = CONTACT_SIDE; hit = 1'b1;
          end
        end
        if ((nx + hx_r) > b.lx && (nx - hx_r) < b.ux) begin
          if ((nz + hz_r) > b.lz && (oz_r + hz_r) <= b.lz) begin
            nz = b.lz - hz_r; nsz = 1'b1; ncontact = CONTACT_SIDE; hit = 1'b1;
          end else if ((nz - hz_r) < b.uz && (oz_r - hz_r) >= b.uz) begin
            nz = b.uz + hz_r + NUDGE; nsz = 1'b1; ncontact = CONTACT_SIDE; hit = 1'b1;
          end
        end
      end
      if ((nz + hz_r) > b.lz && (nz - hz_r) < b.uz &&
          (nx + hx_r) > b.lx && (nx - hx_r) < b.ux) begin
        if ((ny + hy_r) > b.ly && (oy_r + hy_r) <= b.ly) begin
          ny = b.ly - hy_r; nsy = 1'b1; ncontact = CONTACT_UNDER; hit = 1'b1;
        end else if ((ny - hy_r) < b.uy && (oy_r - hy_r) >= b.uy) begin
          ny = b.uy + hy_r; nsy = 1'b1; ncontact = CONTACT_TOP; hit = 1'b1;
        end
      end
    end
  end

  // Next state and address.
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    case (state_r)
      ST_IDLE: begin
        addr_nxt = '0;
        if (start) begin
          state_nxt = (in_beat.kind == KIND_QUERY) ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        if (!addr_r[IDX_BITS]) begin
          addr_nxt = addr_r + 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      addr_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      addr_r    <= addr_nxt;
      out_vld_r <= (state_r == ST_DONE);
    end
  end

  // Hold query operands, advance running position and register the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_beat.a_x; py_r <= in_beat.a_y; pz_r <= in_beat.a_z;
      ox_r <= in_beat.b_x; oy_r <= in_beat.b_y; oz_r <= in_beat.b_z;
      hx_r <= coord_t'({1'b0, in_beat.half_x});
      hy_r <= coord_t'({1'b0, in_beat.half_y});
      hz_r <= coord_t'({1'b0, in_beat.half_z});
      contact_r <= CONTACT_NONE;
      found_r <= 1'b0; last_r <= '0;
      sx_r <= 1'b0; sy_r <= 1'b0; sz_r <= 1'b0;
    end else if (state_r == ST_WALK) begin
      px_r <= nx; py_r <= ny; pz_r <= nz;
      contact_r <= ncontact; sx_r <= nsx; sy_r <= nsy; sz_r <= nsz;
      if (hit) begin
        found_r <= 1'b1;
        last_r  <= rd_idx_r;
      end
    end
    if (state_r == ST_DONE) begin
      if (kind_q_r == KIND_WRITE) begin
        out_r <= '0;
      end else begin
        out_r <= '{contact_r, found_r, last_r, px_r, py_r, pz_r, sx_r, sy_r, sz_r};
      end
    end
  end

  // Remember item kind for the result.
  always_ff @(posedge clk) begin
    if (accept) kind_q_r <= in_beat.kind;
  end

  assign out_valid = out_vld_r;
  assign out_beat  = out_r;

endmodule

// File: bench/box_table_collision_resolve_tb.sv
// Testbench: drives table writes and collision queries, checks each result against a local model.
`timescale 1ns / 1ps
module box_table_collision_resolve_tb;
  import btcr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_beat;
  logic      out_valid;
  out_beat_t out_beat;

  box_table_collision_resolve i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

  // Clock: 4 ns period
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Local copy of the obstacle table
  logic   live_tbl [BOX_COUNT];
  box_t   box_tbl  [BOX_COUNT];

  in_beat_t  pending_beats [$];
  out_beat_t expected_hits [$];
  int        mismatch_count;
  int        watchdog;
  bit        stim_done;

  // Resolve one beat into its expected result and update the table
  function automatic out_beat_t resolve_beat(input in_beat_t b);
    out_beat_t r;
    coord_t    px, py, pz, ox, oy, oz, hx, hy, hz;
    box_t      bx;
    logic      hit;
    r = '0;
    if (b.kind == KIND_WRITE) begin
      live_tbl[b.entry_index] = b.entry_active;
      box_tbl[b.entry_index]  = '{b.a_x, b.a_y, b.a_z, b.b_x, b.b_y, b.b_z};
      return r;
    end
    px = b.a_x; py = b.a_y; pz = b.a_z;
    ox = b.b_x; oy = b.b_y; oz = b.b_z;
    hx = coord_t'({1'b0, b.half_x});
    hy = coord_t'({1'b0, b.half_y});
    hz = coord_t'({1'b0, b.half_z});
    for (int i = 0; i < BOX_COUNT; i++) begin
      if (!live_tbl[i]) continue;
      bx  = box_tbl[i];
      hit = 1'b0;
      if (coord_t'(py + hy) > bx.ly && coord_t'(py - hy) < bx.uy) begin
        // side X faces use the Z half width
        if (coord_t'(pz + hz) > bx.lz && coord_t'(pz - hz) < bx.uz) begin
          if (coord_t'(px + hz) > bx.lx && coord_t'(ox + hz) <= bx.lx) begin
            px = bx.lx - hz; r.stop_x = 1'b1; r.contact = CONTACT_SIDE; hit = 1'b1;
          end else if (coord_t'(px - hz) < bx.ux && coord_t'(ox - hz) >= bx.ux) begin
            px = bx.ux + hz; r.stop_x = 1'b1; r.contact = CONTACT_SIDE; hit = 1'b1;
          end
        end
        if (coord_t'(px + hx) > bx.lx && coord_t'(px - hx) < bx.ux) begin
          if (coord_t'(pz + hz) > bx.lz && coord_t'(oz + hz) <= bx.lz) begin
            pz = bx.lz - hz; r.stop_z = 1'b1; r.contact = CONTACT_SIDE; hit = 1'b1;
          end else if (coord_t'(pz - hz) < bx.uz && coord_t'(oz - hz) >= bx.uz) begin
            // far Z face gets a small nudge
            pz = bx.uz + hz + NUDGE; r.stop_z = 1'b1; r.contact = CONTACT_SIDE;
            hit = 1'b1;
          end
        end
      end
      if (coord_t'(pz + hz) > bx.lz && coord_t'(pz - hz) < bx.uz &&
          coord_t'(px + hx) > bx.lx && coord_t'(px - hx) < bx.ux) begin
        if (coord_t'(py + hy) > bx.ly && coord_t'(oy + hy) <= bx.ly) begin
          py = bx.ly - hy; r.stop_y = 1'b1; r.contact = CONTACT_UNDER; hit = 1'b1;
        end else if (coord_t'(py - hy) < bx.uy && coord_t'(oy - hy) >= bx.uy) begin
          py = bx.uy + hy; r.stop_y = 1'b1; r.contact = CONTACT_TOP; hit = 1'b1;
        end
      end
      if (hit) begin
        r.hit_found = 1'b1;
        r.hit_entry = IDX_BITS'(i);
      end
    end
    r.out_x = px; r.out_y = py; r.out_z = pz;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    mismatch_count++;
  endtask

  // Random coordinate: mostly small, sometimes anywhere
  function automatic coord_t rand_coord();
    if ($urandom_range(0, 9) == 0) return coord_t'($urandom);
    return coord_t'($signed($urandom_range(0, 8192)) - 4096);
  endfunction

  function automatic logic [HALF_BITS-1:0] rand_half();
    if ($urandom_range(0, 19) == 0) return HALF_BITS'($urandom);
    return HALF_BITS'($urandom_range(0, 1024));
  endfunction

  function automatic in_beat_t make_write(input int idx, input logic act,
                                          input coord_t lo_x, lo_y, lo_z,
                                          input coord_t hi_x, hi_y, hi_z);
    in_beat_t b;
    b = in_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    b.kind = KIND_WRITE; b.entry_index = IDX_BITS'(idx); b.entry_active = act;
    b.a_x = lo_x; b.a_y = lo_y; b.a_z = lo_z;
    b.b_x = hi_x; b.b_y = hi_y; b.b_z = hi_z;
    return b;
  endfunction

  function automatic in_beat_t make_query(input coord_t nx, ny, nz, ox, oy, oz,
                                          input logic [HALF_BITS-1:0] hx, hy, hz);
    in_beat_t b;
    b = in_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    b.kind = KIND_QUERY;
    b.a_x = nx; b.a_y = ny; b.a_z = nz;
    b.b_x = ox; b.b_y = oy; b.b_z = oz;
    b.half_x = hx; b.half_y = hy; b.half_z = hz;
    return b;
  endfunction

  // Fill the stimulus queue
  initial begin
    coord_t cx, cy, cz, s;
    int     k;
    stim_done = 1'b0;
    // Directed: cube of half width 256 at entry 0, approach from every face
    pending_beats.push_back(make_write(0, 1'b1, -24'sd256, -24'sd256, -24'sd256,
                                       24'sd256, 24'sd256, 24'sd256));
    pending_beats.push_back(make_query(-24'sd200, 24'sd0, 24'sd0, -24'sd1000, 24'sd0,
                                       24'sd0, 23'd128, 23'd128, 23'd128));
    pending_beats.push_back(make_query(24'sd200, 24'sd0, 24'sd0, 24'sd1000, 24'sd0,
                                       24'sd0, 23'd128, 23'd128, 23'd128));
    pending_beats.push_back(make_query(24'sd0, 24'sd0, -24'sd200, 24'sd0, 24'sd0,
                                       -24'sd1000, 23'd128, 23'd128, 23'd128));
    pending_beats.push_back(make_query(24'sd0, 24'sd0, 24'sd200, 24'sd0, 24'sd0,
                                       24'sd1000, 23'd128, 23'd128, 23'd128));
    pending_beats.push_back(make_query(24'sd0, -24'sd200, 24'sd0, 24'sd0, -24'sd1000,
                                       24'sd0, 23'd128, 23'd128, 23'd128));
    pending_beats.push_back(make_query(24'sd0, 24'sd200, 24'sd0, 24'sd0, 24'sd1000,
                                       24'sd0, 23'd128, 23'd128, 23'd128));
    pending_beats.push_back(make_query(24'sd0, 24'sd1000, 24'sd0, 24'sd0, 24'sd1000,
                                       24'sd0, 23'd0, 23'd0, 23'd0));
    // Extreme fields, wrap, inverted box, last entry
    pending_beats.push_back(make_write(63, 1'b1, 24'sh7FFF00, 24'sh7FFF00, 24'sh7FFF00,
                                       24'sh800100, 24'sh800100, 24'sh800100));
    pending_beats.push_back(make_query(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000,
                                       24'sh7FFFFF, 24'sh800000, 23'h7FFFFF, 23'h7FFFFF,
                                       23'h7FFFFF));
    pending_beats.push_back(make_query(24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
                                       24'sh800000, 24'sh7FFFFF, 23'd0, 23'd0, 23'd0));
    pending_beats.push_back(make_write(63, 1'b0, 24'sd0, 24'sd0, 24'sd0,
                                       24'sd0, 24'sd0, 24'sd0));
    pending_beats.push_back(make_write(5, 1'b1, 24'sd300, -24'sd256, -24'sd256,
                                       -24'sd300, 24'sd256, 24'sd256));
    pending_beats.push_back(make_query(24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
                                       23'd128, 23'd128, 23'd128));
    pending_beats.push_back(make_write(5, 1'b0, 24'sd0, 24'sd0, 24'sd0,
                                       24'sd0, 24'sd0, 24'sd0));
    // Random: table edits with queries that mostly cross nearby boxes
    for (int n = 0; n < 1140; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        cx = rand_coord(); cy = rand_coord(); cz = rand_coord();
        s  = coord_t'($urandom_range(0, 1024));
        if ($urandom_range(0, 7) == 0) s = coord_t'(-$signed($urandom_range(0, 512)));
        pending_beats.push_back(make_write($urandom_range(0, 63), $urandom_range(0, 3) != 0,
                                           cx, cy, cz, cx + s, cy + s, cz + s));
      end else begin
        k  = $urandom_range(0, 2000);
        cx = rand_coord(); cy = rand_coord(); cz = rand_coord();
        pending_beats.push_back(make_query(cx, cy, cz,
            cx + coord_t'($signed($urandom_range(0, 2 * k)) - k),
            cy + coord_t'($signed($urandom_range(0, 2 * k)) - k),
            cz + coord_t'($signed($urandom_range(0, 2 * k)) - k),
            rand_half(), rand_half(), rand_half()));
      end
    end
    stim_done = 1'b1;
  end

  // Driver: present beats from the queue with random gaps
  int gap_count;
  always @(posedge clk) begin
    if (!rst_n) begin
      start     <= 1'b0;
      in_beat   <= '0;
      gap_count <= 0;
    end else if (start && !busy) begin
      // beat accepted at this edge
      void'(pending_beats.pop_front());
      expected_hits.push_back(resolve_beat(in_beat));
      start     <= 1'b0;
      gap_count <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    end else if (!start) begin
      if (gap_count > 0) begin
        gap_count <= gap_count - 1;
      end else if (pending_beats.size() > 0) begin
        start   <= 1'b1;
        in_beat <= pending_beats[0];
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  out_beat_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_beat), 32'd0);
      end else begin
        want = expected_hits.pop_front();
        if (out_beat.contact !== want.contact)
          report_mismatch("contact", 32'(out_beat.contact), 32'(want.contact));
        if (out_beat.hit_found !== want.hit_found)
          report_mismatch("hit_found", 32'(out_beat.hit_found), 32'(want.hit_found));
        if (out_beat.hit_entry !== want.hit_entry)
          report_mismatch("hit_entry", 32'(out_beat.hit_entry), 32'(want.hit_entry));
        if (out_beat.out_x !== want.out_x)
          report_mismatch("out_x", 32'(out_beat.out_x), 32'(want.out_x));
        if (out_beat.out_y !== want.out_y)
          report_mismatch("out_y", 32'(out_beat.out_y), 32'(want.out_y));
        if (out_beat.out_z !== want.out_z)
          report_mismatch("out_z", 32'(out_beat.out_z), 32'(want.out_z));
        if (out_beat.stop_x !== want.stop_x)
          report_mismatch("stop_x", 32'(out_beat.stop_x), 32'(want.stop_x));
        if (out_beat.stop_y !== want.stop_y)
          report_mismatch("stop_y", 32'(out_beat.stop_y), 32'(want.stop_y));
        if (out_beat.stop_z !== want.stop_z)
          report_mismatch("stop_z", 32'(out_beat.stop_z), 32'(want.stop_z));
      end
    end
  end

  // Watchdog: count cycles with no beat moving
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      watchdog <= 0;
    end else begin
      watchdog <= watchdog + 1;
    end
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Reset, then wait for drain and report
  initial begin
    mismatch_count = 0;
    watchdog       = 0;
    start          = 1'b0;
    in_beat        = '0;
    rst_n          = 1'b0;
    for (int i = 0; i < BOX_COUNT; i++) begin
      live_tbl[i] = 1'b0;
      box_tbl[i]  = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (pending_beats.size() > 0 || start || expected_hits.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_hits.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
